FILE: rtl/core/aescbc_pkg.sv
// Package with AES tables, helper functions, and shared types for the CBC stream core.
package aescbc_pkg;

  localparam int BlockBytes = 16;
  localparam int CfgWidth = 64;
  localparam int CfgIdxWidth = 2;
  localparam int Rounds = 10;
  localparam int QueueDepth = 2;

  localparam logic [CfgIdxWidth-1:0] RegKeyHigh = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegKeyLow = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegIvHigh = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegIvLow = 2'd3;

  // Job handed from the collector to the cipher side.
  typedef enum logic {
    JobCipher = 1'b0,
    JobClear = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic [127:0] data;
    logic [4:0] count;
    logic eom;
    logic restart;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle = 2'd0,
    BkRound = 2'd1,
    BkEmit = 2'd2
  } back_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits in bits 127-8i down to 120-8i.
  function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

  // One round of the key schedule.
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, then AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = sbox(byte_of(s, ((c + r) & 3) * 4 + r));
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4 + 1];
        a2 = t[c*4 + 2];
        a3 = t[c*4 + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4] = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4 + 1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4 + 2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4 + 3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

endpackage

FILE: rtl/core/aescbc_if.sv
// Valid/ready stream interfaces for the input bytes and the result bytes.
interface aescbc_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic end_of_message;
  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface aescbc_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic run_last;
  logic message_done;
  modport source (output valid, out_byte, run_last, message_done, input ready);
  modport sink (input valid, out_byte, run_last, message_done, output ready);
endinterface

FILE: rtl/core/aes128_cbc_encrypt_stream_core.sv
// Top level of the AES-128 CBC byte stream encryptor.
//  channel  | dir | payload                               | handshake
//  in_ch    | in  | data_byte, end_of_message            | valid/ready
//  out_ch   | out | out_byte, run_last, message_done      | valid/ready
//  cfg      | in  | cfg_we, cfg_index, cfg_data (64 bits) | write enable
// A byte is accepted every cycle while the job queue has room.
// A full block is loaded with the chain value and key, runs through the AES rounds, then is output byte by byte;
// a clear tail is loaded and then output byte by byte without encryption.
// Two queued jobs absorb bursts, so bytes are still accepted while the engine works on a block.
// Reset is synchronous and clears the fill count, queue and chain state.
// Input stalls only while the job queue is full.
module aes128_cbc_encrypt_stream_core
  import aescbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  aescbc_in_if.sink in_ch,
  aescbc_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0] cfg_data
);

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic fr_valid, q_not_full, q_not_empty, q_pop;
  job_t fr_job, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      iv_high <= '0;
      iv_low <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKeyHigh: key_high <= cfg_data;
        RegKeyLow: key_low <= cfg_data;
        RegIvHigh: iv_high <= cfg_data;
        RegIvLow: iv_low <= cfg_data;
        default: ;
      endcase
    end
  end

  aescbc_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job_valid(fr_valid), .job_ready(q_not_full), .job(fr_job)
  );

  aescbc_queue u_queue (
    .clk(clk), .rst(rst), .push(fr_valid), .not_full(q_not_full), .push_job(fr_job),
    .not_empty(q_not_empty), .pop(q_pop), .head(q_head)
  );

  aescbc_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_not_empty), .job_pop(q_pop), .job(q_head),
    .key({key_high, key_low}), .iv({iv_high, iv_low}), .out_ch(out_ch)
  );

endmodule

FILE: rtl/core/aescbc_front.sv
// Byte collector: gathers bytes into blocks and issues cipher or clear jobs.
module aescbc_front
  import aescbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  aescbc_in_if.sink in_ch,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  logic [127:0] buffer;
  logic [3:0] fill_count;
  logic [127:0] buffer_next;
  logic take;
  logic full;

  // A byte is taken only when the job it might produce can be queued.
  assign in_ch.ready = job_ready;
  assign take = in_ch.valid && in_ch.ready;
  assign full = (fill_count == 4'(BlockBytes - 1));

  always_comb begin
    buffer_next = buffer;
    buffer_next[127 - 8*fill_count -: 8] = in_ch.data_byte;
  end

  always_comb begin
    job.kind = full ? JobCipher : JobClear;
    job.data = buffer_next;
    job.count = {1'b0, fill_count} + 5'd1;
    job.eom = in_ch.end_of_message;
    job.restart = in_ch.end_of_message;
    job_valid = take && (full || in_ch.end_of_message);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (take) begin
      fill_count <= (full || in_ch.end_of_message) ? 4'd0 : fill_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buffer <= buffer_next;
    end
  end

endmodule

FILE: rtl/core/aescbc_queue.sv
// Two-entry job queue between the collector and the cipher engine.
module aescbc_queue
  import aescbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic not_full,
  input  job_t push_job,
  output logic not_empty,
  input  logic pop,
  output job_t head
);

  job_t slots [QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_full = (count != 2'(QueueDepth));
  assign not_empty = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/core/aescbc_back.sv
// Cipher engine: CBC chaining, iterative AES-128 rounds, and byte serializer.
module aescbc_back
  import aescbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_pop,
  input  job_t job,
  input  logic [127:0] key,
  input  logic [127:0] iv,
  aescbc_out_if.source out_ch
);

  back_state_t state, state_next;
  logic [127:0] data;
  logic [127:0] round_key;
  logic [127:0] chain;
  logic chain_fresh;
  logic [3:0] round;
  logic [7:0] rcon;
  logic [4:0] count;
  logic [3:0] idx;
  logic eom;
  logic [127:0] next_key;
  logic emit_step;
  logic last_byte;

  assign next_key = key_step(round_key, rcon);
  assign emit_step = out_ch.valid && out_ch.ready;
  assign last_byte = ({1'b0, idx} == count - 5'd1);

  assign out_ch.valid = (state == BkEmit);
  assign out_ch.out_byte = data[127 - 8*idx -: 8];
  assign out_ch.run_last = last_byte;
  assign out_ch.message_done = last_byte && eom;

  always_comb begin
    state_next = state;
    job_pop = 1'b0;
    unique case (state)
      BkIdle: begin
        if (job_valid) begin
          job_pop = 1'b1;
          state_next = (job.kind == JobCipher) ? BkRound : BkEmit;
        end
      end
      BkRound: begin
        if (round == 4'(Rounds)) state_next = BkEmit;
      end
      BkEmit: begin
        if (emit_step && last_byte) state_next = BkIdle;
      end
      default: state_next = BkIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BkIdle;
      chain_fresh <= 1'b1;
    end else begin
      state <= state_next;
      if (state == BkIdle && job_valid && job.kind == JobCipher) begin
        chain_fresh <= 1'b0;
      end
      if (state == BkIdle && job_valid && job.restart) begin
        chain_fresh <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BkIdle: begin
        if (job_valid) begin
          count <= job.count;
          eom <= job.eom;
          idx <= '0;
          round <= 4'd1;
          rcon <= 8'h01;
          round_key <= key;
          if (job.kind == JobCipher) begin
            data <= job.data ^ (chain_fresh ? iv : chain) ^ key;
          end else begin
            data <= job.data;
          end
        end
      end
      BkRound: begin
        data <= aes_round(data, next_key, round == 4'(Rounds));
        round_key <= next_key;
        rcon <= xtime(rcon);
        round <= round + 4'd1;
        if (round == 4'(Rounds)) begin
          chain <= aes_round(data, next_key, 1'b1);
        end
      end
      BkEmit: begin
        if (emit_step) idx <= idx + 4'd1;
      end
      default: ;
    endcase
  end

endmodule
